// ===== design/pnbd_pkg.sv =====
// Shared types, constants and helper functions for the PCM box downsampler.
package pnbd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 16;
  localparam int NORM_W    = 24;
  localparam int ACC_W     = 44;
  localparam int RATIO_W   = 21;
  localparam int INV_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = NORM_W + INV_W;
  localparam int HALF_W    = ACC_W / 2;

  localparam logic [RATIO_W-1:0] ONE_FIX     = RATIO_W'(1) << FRAC_BITS;
  localparam logic [RATIO_W-1:0] RATIO_RESET = ONE_FIX;
  localparam logic [INV_W-1:0]   INV_RESET   = INV_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_FORMAT = 2'd0,
    CFG_STEREO       = 2'd1,
    CFG_STEP_RATIO   = 2'd2,
    CFG_INV_RATIO    = 2'd3
  } pnbd_cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_frame;
  } pnbd_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       run_end;
  } pnbd_out_t;

  typedef struct packed {
    logic               input_format;
    logic               stereo;
    logic [RATIO_W-1:0] step_ratio;
    logic [INV_W-1:0]   inv_ratio;
  } pnbd_cfg_t;

  typedef struct packed {
    logic               restart;
    logic [RATIO_W-1:0] ratio;
  } pnbd_restart_t;

  typedef struct packed {
    logic              bypass;
    logic              last;
    logic [NORM_W-1:0] xl;
    logic [NORM_W-1:0] xr;
  } pnbd_job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYP,
    S_WMUL,
    S_WACC,
    S_SLO,
    S_SHI,
    S_SSUM,
    S_RMUL,
    S_RSET,
    S_EMIT1,
    S_ADD,
    S_FLUSH,
    S_DIV,
    S_EMIT2
  } pnbd_state_t;

  // 16-bit signed or 8-bit unsigned sample to 24-bit offset binary
  function automatic logic [NORM_W-1:0] normalize(input logic fmt8,
                                                  input logic [SAMPLE_W-1:0] raw);
    logic [NORM_W-1:0] v;
    if (fmt8) begin
      v = {raw[7:0], 16'h0000};
    end else begin
      v = {~raw[15], raw[14:0], 8'h00};
    end
    return v;
  endfunction

  // 24-bit offset binary to signed 16-bit, saturating on overflow
  function automatic logic [SAMPLE_W-1:0] to_s16(input logic ovf,
                                                 input logic [NORM_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    if (ovf) begin
      r = 16'h7FFF;
    end else begin
      r = v[NORM_W-1:8] ^ 16'h8000;
    end
    return r;
  endfunction

endpackage

// ===== design/pnbd_front.sv =====
// Front end: takes input items, normalizes samples and classifies bypass.
module pnbd_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pnbd_pkg::pnbd_in_t    in_data,
  input  pnbd_pkg::pnbd_cfg_t   cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output pnbd_pkg::pnbd_job_t   q_job
);
  import pnbd_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_job.bypass = (cfg.step_ratio <= ONE_FIX);
    q_job.last   = in_data.last_frame;
    q_job.xl     = normalize(cfg.input_format, in_data.left_sample);
    // mono drops the right sample here
    q_job.xr     = cfg.stereo ? normalize(cfg.input_format, in_data.right_sample)
                              : '0;
  end

endmodule

// ===== design/pnbd_fifo.sv =====
// Two-entry queue of classified items between front and back.
module pnbd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pnbd_pkg::pnbd_job_t push_job,
  input  logic                pop,
  output pnbd_pkg::pnbd_job_t head,
  output logic                full,
  output logic                empty
);
  import pnbd_pkg::*;

  pnbd_job_t  ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/pnbd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the flush average.
module pnbd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pnbd_pkg::ACC_W-1:0]    dividend,
  input  logic [pnbd_pkg::RATIO_W-1:0]  divisor,
  output logic                          done,
  output logic [pnbd_pkg::ACC_W-1:0]    quotient
);
  import pnbd_pkg::*;

  localparam int CNT_W = $clog2(ACC_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ACC_W-1:0]    dq_r, dq_nxt;
  logic [RATIO_W-1:0]  rem_r, rem_nxt;
  logic [RATIO_W-1:0]  dvs_r, dvs_nxt;
  logic [RATIO_W:0]    trial;
  logic                ge;

  assign trial    = {rem_r, dq_r[ACC_W-1]};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = dq_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      rem_nxt = ge ? RATIO_W'(trial - {1'b0, dvs_r}) : trial[RATIO_W-1:0];
      dq_nxt  = {dq_r[ACC_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

// ===== design/pnbd_back.sv =====
// Back end: weighting, accumulation, scaling, flush and the output register.
module pnbd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pnbd_pkg::pnbd_cfg_t    cfg,
  input  pnbd_pkg::pnbd_restart_t rst_ctl,
  input  pnbd_pkg::pnbd_job_t    q_head,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pnbd_pkg::pnbd_out_t    out_data
);
  import pnbd_pkg::*;

  pnbd_state_t          state_r, state_nxt;
  logic                 ch_r, ch_nxt;
  pnbd_job_t            job_r, job_nxt;
  logic [RATIO_W-1:0]   frac_r, frac_nxt;
  logic [ACC_W-1:0]     accl_r, accl_nxt;
  logic [ACC_W-1:0]     accr_r, accr_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [PROD_W-3:0]    lo_r, lo_nxt;
  logic [SAMPLE_W-1:0]  resl_r, resl_nxt;
  logic [SAMPLE_W-1:0]  resr_r, resr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pnbd_out_t            out_data_r, out_data_nxt;

  logic [NORM_W-1:0]    x_sel;
  logic [ACC_W-1:0]     acc_sel;
  logic [INV_W-1:0]     rest;
  logic [RATIO_W-1:0]   weight;
  logic [NORM_W-1:0]    mul_a;
  logic [INV_W-1:0]     mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [ACC_W+INV_W:0] scale_sum;
  logic [SAMPLE_W-1:0]  scaled16;
  logic [SAMPLE_W-1:0]  div16;
  logic                 slot_free;
  logic                 more_ch;
  logic                 div_start;
  logic                 div_done;
  logic [ACC_W-1:0]     div_q;

  assign x_sel     = ch_r ? job_r.xr : job_r.xl;
  assign acc_sel   = ch_r ? accr_r : accl_r;
  assign rest      = INV_W'(ONE_FIX - {5'b0, frac_r[FRAC_BITS-1:0]});
  assign weight    = (cfg.step_ratio >= frac_r) ? cfg.step_ratio - frac_r : '0;
  assign slot_free = !out_valid_r || !out_stall;
  assign more_ch   = cfg.stereo && !ch_r;
  assign mul_p     = {{INV_W{1'b0}}, mul_a} * {{NORM_W{1'b0}}, mul_b};

  // high partial product weighs 2^22, then drop the 2*FRAC_BITS fraction bits
  assign scale_sum = {prod_r[PROD_W-3:0], {HALF_W{1'b0}}} +
                     {{(HALF_W+1){1'b0}}, lo_r};
  assign scaled16  = to_s16(|scale_sum[ACC_W+INV_W:2*FRAC_BITS+NORM_W],
                            scale_sum[2*FRAC_BITS +: NORM_W]);
  assign div16     = to_s16(|div_q[ACC_W-1:NORM_W], div_q[NORM_W-1:0]);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pnbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_sel),
    .divisor  (weight),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    unique case (state_r)
      S_WMUL: begin
        mul_a = x_sel;
        mul_b = {1'b0, frac_r[FRAC_BITS-1:0]};
      end
      S_SLO: begin
        mul_a = {2'b0, acc_sel[HALF_W-1:0]};
        mul_b = cfg.inv_ratio;
      end
      S_SHI: begin
        mul_a = {2'b0, acc_sel[ACC_W-1:HALF_W]};
        mul_b = cfg.inv_ratio;
      end
      S_RMUL: begin
        mul_a = x_sel;
        mul_b = rest;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    job_nxt       = job_r;
    frac_nxt      = frac_r;
    accl_nxt      = accl_r;
    accr_nxt      = accr_r;
    prod_nxt      = prod_r;
    lo_nxt        = lo_r;
    resl_nxt      = resl_r;
    resr_nxt      = resr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && !rst_ctl.restart) begin
          q_pop   = 1'b1;
          job_nxt = q_head;
          ch_nxt  = 1'b0;
          if (q_head.bypass) begin
            state_nxt = S_BYP;
          end else if (frac_r < ONE_FIX) begin
            state_nxt = S_WMUL;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_BYP: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.left_out  = to_s16(1'b0, job_r.xl);
          out_data_nxt.right_out = cfg.stereo ? to_s16(1'b0, job_r.xr) : '0;
          out_data_nxt.run_end   = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      S_WMUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_WACC;
      end
      S_WACC: begin
        if (ch_r) begin
          accr_nxt = accr_r + ACC_W'(prod_r);
        end else begin
          accl_nxt = accl_r + ACC_W'(prod_r);
        end
        state_nxt = S_SLO;
      end
      S_SLO: begin
        prod_nxt  = mul_p;
        state_nxt = S_SHI;
      end
      S_SHI: begin
        lo_nxt    = prod_r[PROD_W-3:0];
        prod_nxt  = mul_p;
        state_nxt = S_SSUM;
      end
      S_SSUM: begin
        if (ch_r) begin
          resr_nxt = scaled16;
        end else begin
          resl_nxt = scaled16;
        end
        if (more_ch) begin
          ch_nxt    = 1'b1;
          state_nxt = S_WMUL;
        end else begin
          ch_nxt    = 1'b0;
          state_nxt = S_RMUL;
        end
      end
      S_RMUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_RSET;
      end
      S_RSET: begin
        // leftover weight of this frame opens the next output
        if (ch_r) begin
          accr_nxt = ACC_W'(prod_r);
        end else begin
          accl_nxt = ACC_W'(prod_r);
        end
        if (more_ch) begin
          ch_nxt    = 1'b1;
          state_nxt = S_RMUL;
        end else begin
          ch_nxt    = 1'b0;
          frac_nxt  = cfg.step_ratio - RATIO_W'(rest);
          state_nxt = S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.left_out  = resl_r;
          out_data_nxt.right_out = cfg.stereo ? resr_r : '0;
          out_data_nxt.run_end   = !job_r.last;
          state_nxt              = job_r.last ? S_FLUSH : S_IDLE;
        end
      end
      S_ADD: begin
        accl_nxt = accl_r + ACC_W'({job_r.xl, {FRAC_BITS{1'b0}}});
        if (cfg.stereo) begin
          accr_nxt = accr_r + ACC_W'({job_r.xr, {FRAC_BITS{1'b0}}});
        end
        frac_nxt  = frac_r - ONE_FIX;
        state_nxt = job_r.last ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        if (weight == '0) begin
          resl_nxt  = '0;
          resr_nxt  = '0;
          state_nxt = S_EMIT2;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (ch_r) begin
            resr_nxt = div16;
          end else begin
            resl_nxt = div16;
          end
          if (more_ch) begin
            ch_nxt    = 1'b1;
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_EMIT2;
          end
        end
      end
      S_EMIT2: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.left_out  = resl_r;
          out_data_nxt.right_out = cfg.stereo ? resr_r : '0;
          out_data_nxt.run_end   = 1'b1;
          frac_nxt               = cfg.step_ratio;
          accl_nxt               = '0;
          accr_nxt               = '0;
          ch_nxt                 = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a ratio write restarts the run
    if (rst_ctl.restart) begin
      frac_nxt = rst_ctl.ratio;
      accl_nxt = '0;
      accr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      frac_r      <= RATIO_RESET;
      accl_r      <= '0;
      accr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      frac_r      <= frac_nxt;
      accl_r      <= accl_nxt;
      accr_r      <= accr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    prod_r     <= prod_nxt;
    lo_r       <= lo_nxt;
    resl_r     <= resl_nxt;
    resr_r     <= resr_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_frac_le_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r <= cfg.step_ratio)
    else $error("remaining fraction above step ratio");

  a_mono_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !cfg.stereo |-> out_data_r.right_out == '0)
    else $error("mono result carries a right sample");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside flush");

  a_weight_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WMUL |-> frac_r < ONE_FIX)
    else $error("partial weight step with full fraction");
`endif

endmodule

// ===== design/pcm_normalize_box_downsampler_unit.sv =====
// Top level of the PCM normalize and box-filter downsampler.
//
// Input channel in_valid/in_stall carries one PCM frame per item (left,
// right, last_frame). The front normalizes samples to 24-bit offset binary
// and queues them in a two-entry queue; the back runs them one at a time.
// Result channel out_valid/out_stall carries 0, 1 or 2 results per frame;
// run_end marks the last result of a frame.
// Work per item, from queue pop: bypass (ratio <= 1.0) sends the sample; a frame
// that only accumulates adds into the accumulators; a frame that closes an output
// weighs, scales and sets the remainder per channel, all on the single shared
// 24x17 multiplier. A last frame then flushes each channel through the restoring
// divider, one quotient bit per cycle, and sends the flush result.
// Configuration cfg_valid/cfg_ready is always ready; write only while idle.
// Writing the step ratio reloads the fraction and clears the accumulators.
// Reset (rst_n low, synchronous) gives 16-bit mono, ratio 1.0, empty queue.
// A stalled receiver holds the output register; the back waits for it and
// the queue then fills and raises in_stall.
module pcm_normalize_box_downsampler_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pnbd_pkg::pnbd_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pnbd_pkg::pnbd_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pnbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pnbd_pkg::RATIO_W-1:0]       cfg_wdata
);
  import pnbd_pkg::*;

  pnbd_cfg_t     cfg_r, cfg_nxt;
  pnbd_restart_t rst_ctl;
  pnbd_job_t     push_job;
  pnbd_job_t     q_head;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic          cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt         = cfg_r;
    rst_ctl.restart = 1'b0;
    rst_ctl.ratio   = cfg_wdata;
    if (cfg_we) begin
      unique case (pnbd_cfg_idx_t'(cfg_index))
        CFG_INPUT_FORMAT: cfg_nxt.input_format = cfg_wdata[0];
        CFG_STEREO:       cfg_nxt.stereo       = cfg_wdata[0];
        CFG_STEP_RATIO: begin
          cfg_nxt.step_ratio = cfg_wdata;
          rst_ctl.restart    = 1'b1;
        end
        CFG_INV_RATIO:    cfg_nxt.inv_ratio    = cfg_wdata[INV_W-1:0];
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_format <= 1'b0;
      cfg_r.stereo       <= 1'b0;
      cfg_r.step_ratio   <= RATIO_RESET;
      cfg_r.inv_ratio    <= INV_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pnbd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  pnbd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pnbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rst_ctl   (rst_ctl),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
